// File: hw/rtl/pfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared request/response types and constants of the paging frame allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

  // request function codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // response status codes
  localparam logic [1:0] STATUS_DONE       = 2'd0;
  localparam logic [1:0] STATUS_REFUSED    = 2'd1;
  localparam logic [1:0] STATUS_NONE_OWNED = 2'd2;

  // owner table valid bit of a frame nobody holds
  localparam logic OWNER_NONE = 1'b0;

  localparam logic [24:0] BYTES_MAX = 25'h1FF_FFFF;
  localparam logic [8:0]  LIVE_MAX  = 9'd511;
  localparam logic [16:0] BPF_RESET = 17'd4096;

  typedef struct packed {
    logic        func;
    logic [15:0] process_id;
    logic [8:0]  pages_needed;
  } pfa_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  first_frame;
    logic [8:0]  frames_moved;
    logic [24:0] used_bytes;
    logic [24:0] free_bytes;
    logic [31:0] paged_in_total;
    logic [31:0] paged_out_total;
    logic [8:0]  process_count;
  } pfa_rsp_t;

endpackage

// File: hw/rtl/pfa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pfa_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/pfa_byte_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_byte_mul
// Frames times bytes per frame, registered, saturated to the report width.
// ----------------------------------------------------------------------------
module pfa_byte_mul
  import pfa_pkg::*;
#(
  parameter int FCW = 9
) (
  input  logic           clk,
  input  logic [FCW-1:0] frames,
  input  logic [16:0]    bpf,
  output logic [24:0]    bytes
);

  // product width, never narrower than the report
  localparam int PW = (FCW + 17 > 25) ? FCW + 17 : 25;

  logic [PW-1:0] prod;

  // one multiply per cycle
  always_ff @(posedge clk) begin
    prod <= PW'(frames) * PW'(bpf);
  end

  // clamp to report range
  assign bytes = (prod > PW'(BYTES_MAX)) ? BYTES_MAX : prod[24:0];

endmodule

// File: hw/rtl/paging_frame_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paging_frame_allocator_top
// Frame allocator with a free-frame queue and a frame owner table.
// ----------------------------------------------------------------------------
// After reset the block fills the free queue and clears the owner table,
// with busy high. An accepted allocate request keeps busy high for one queue
// read and owner write per frame, a refused one while the response is
// built, and a free request for the owner table scan, one entry per cycle.
// The result appears for one cycle with done, in the same cycle busy falls,
// and must be taken then; the receiver cannot stall. bytes_per_frame is
// written on the cfg channel while idle.
module paging_frame_allocator_top
  import pfa_pkg::*;
#(
  parameter int FRAMES   = 256,
  parameter int PID_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  pfa_req_t    req,
  output logic        done,
  output pfa_rsp_t    rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data
);

  localparam int QW  = $clog2(FRAMES);
  localparam int FCW = $clog2(FRAMES + 1);
  localparam int OW  = PID_BITS + 1;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_ALLOC, S_FREE, S_MUL_A, S_MUL_B, S_RESP
  } state_t;

  state_t              state;
  logic [FCW-1:0]      idx;
  logic [FCW-1:0]      need;
  logic [FCW-1:0]      moved;
  logic [QW-1:0]       head;
  logic [QW-1:0]       tail;
  logic [FCW-1:0]      free_count;
  logic [31:0]         pin;
  logic [31:0]         pout;
  logic [8:0]          live;
  logic [PID_BITS-1:0] pid;
  logic [16:0]         bpf;
  logic                rd_pend;
  logic                first_pend;
  logic [QW-1:0]       rd_idx;

  logic                q_we;
  logic [QW-1:0]       q_waddr;
  logic [QW-1:0]       q_wdata;
  logic [QW-1:0]       q_rdata;
  logic                o_we;
  logic [QW-1:0]       o_waddr;
  logic [OW-1:0]       o_wdata;
  logic [OW-1:0]       o_rdata;
  logic [FCW-1:0]      mul_frames;
  logic [24:0]         mul_bytes;
  logic                match;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign match     = rd_pend && o_rdata[OW-1] && (o_rdata[PID_BITS-1:0] == pid);

  pfa_ram #(.DEPTH(FRAMES), .WIDTH(QW)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(head), .rdata(q_rdata)
  );

  pfa_ram #(.DEPTH(FRAMES), .WIDTH(OW)) u_owner (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
    .raddr(idx[QW-1:0]), .rdata(o_rdata)
  );

  pfa_byte_mul #(.FCW(FCW)) u_mul (
    .clk(clk), .frames(mul_frames), .bpf(bpf), .bytes(mul_bytes)
  );

  // memory write ports
  always_comb begin
    q_we    = 1'b0;
    q_waddr = tail;
    q_wdata = rd_idx;
    o_we    = 1'b0;
    o_waddr = rd_idx;
    o_wdata = {OWNER_NONE, {PID_BITS{1'b0}}};
    unique case (state)
      S_INIT: begin
        q_we    = 1'b1;
        q_waddr = idx[QW-1:0];
        q_wdata = idx[QW-1:0];
        o_we    = 1'b1;
        o_waddr = idx[QW-1:0];
      end
      S_ALLOC: begin
        o_we    = rd_pend;
        o_waddr = q_rdata;
        o_wdata = {1'b1, pid};
      end
      S_FREE: begin
        q_we = match;
        o_we = match;
      end
      default: begin
      end
    endcase
  end

  // multiplier operand: used frames first, then free frames
  assign mul_frames = (state == S_MUL_A) ? FCW'(FRAMES) - free_count : free_count;

  // control, counters and registered response
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      idx        <= '0;
      head       <= '0;
      tail       <= '0;
      free_count <= FCW'(FRAMES);
      pin        <= '0;
      pout       <= '0;
      live       <= '0;
      bpf        <= BPF_RESET;
      rd_pend    <= 1'b0;
      first_pend <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        bpf <= cfg_data;
      end
      unique case (state)
        S_INIT: begin
          idx <= idx + 1'b1;
          if (idx == FCW'(FRAMES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          idx        <= '0;
          moved      <= '0;
          rd_pend    <= 1'b0;
          first_pend <= 1'b1;
          pid        <= PID_BITS'(req.process_id);
          need       <= FCW'(req.pages_needed);
          rsp.status       <= STATUS_DONE;
          rsp.first_frame  <= '0;
          rsp.frames_moved <= '0;
          if (start) begin
            if (req.func == FUNC_FREE) begin
              state <= S_FREE;
            end else if (req.pages_needed == 9'd0 ||
                         32'(req.pages_needed) > 32'(free_count)) begin
              rsp.status <= STATUS_REFUSED;
              state      <= S_MUL_A;
            end else begin
              free_count       <= free_count - FCW'(req.pages_needed);
              pin              <= pin + 32'(req.pages_needed);
              rsp.frames_moved <= req.pages_needed;
              if (live < LIVE_MAX) begin
                live <= live + 1'b1;
              end
              state <= S_ALLOC;
            end
          end
        end
        S_ALLOC: begin
          // issue queue reads at the head, write owners in the following cycle
          rd_pend <= (idx != need);
          if (idx != need) begin
            idx  <= idx + 1'b1;
            head <= (head == QW'(FRAMES - 1)) ? '0 : head + 1'b1;
          end
          if (rd_pend && first_pend) begin
            rsp.first_frame <= 8'(q_rdata);
            first_pend      <= 1'b0;
          end
          if (idx == need && !rd_pend) begin
            state <= S_MUL_A;
          end
        end
        S_FREE: begin
          // scan owner entries, release matches in the cycle after the read
          rd_pend <= (idx != FCW'(FRAMES));
          rd_idx  <= idx[QW-1:0];
          if (idx != FCW'(FRAMES)) begin
            idx <= idx + 1'b1;
          end
          if (match) begin
            tail       <= (tail == QW'(FRAMES - 1)) ? '0 : tail + 1'b1;
            free_count <= free_count + 1'b1;
            moved      <= moved + 1'b1;
          end
          if (idx == FCW'(FRAMES) && !rd_pend) begin
            rsp.frames_moved <= 9'(moved);
            if (moved == '0) begin
              rsp.status <= STATUS_NONE_OWNED;
            end else begin
              pout <= pout + 32'(moved);
              if (live != 9'd0) begin
                live <= live - 1'b1;
              end
            end
            state <= S_MUL_A;
          end
        end
        S_MUL_A: begin
          state <= S_MUL_B;
        end
        S_MUL_B: begin
          rsp.used_bytes <= mul_bytes;
          state          <= S_RESP;
        end
        S_RESP: begin
          rsp.free_bytes      <= mul_bytes;
          rsp.paged_in_total  <= pin;
          rsp.paged_out_total <= pout;
          rsp.process_count   <= live;
          done                <= 1'b1;
          state               <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // free frame count never exceeds the frame total
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= FCW'(FRAMES))
    else $error("free frame count above frame total");

  // a response only follows the response state
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_RESP))
    else $error("done without response state");

  // a refused allocate moves no frames
  a_refused: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == STATUS_REFUSED) |-> (rsp.frames_moved == 9'd0))
    else $error("refused request moved frames");

  // the block is busy while a response is being built
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL_A) |=> busy)
    else $error("not busy while building response");
`endif

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the paging frame allocator. Allocate and free
// requests are driven with random gaps, a behavioral copy of the free queue
// and owner table predicts every response, and responses are checked field
// by field as they come out. bytes_per_frame is rewritten between phases.
// ----------------------------------------------------------------------------
module tb
  import pfa_pkg::*;
;

  localparam int NFRAMES  = 256;
  localparam int SETTLE   = 8;
  localparam int WD_LIMIT = 5000;

  typedef enum logic [1:0] {OP_REQ, OP_CFG, OP_DRAIN} op_kind_t;

  typedef struct {
    op_kind_t    kind;
    pfa_req_t    req;
    logic [16:0] cfg;
    int          gap;
  } step_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  pfa_req_t    req;
  logic        done;
  pfa_rsp_t    rsp;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [16:0] cfg_data;

  paging_frame_allocator_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // allocator image kept by the bench
  logic [7:0]  free_list [NFRAMES];
  logic [7:0]  list_head;
  logic [7:0]  list_tail;
  int          free_frames;
  logic        held [NFRAMES];
  logic [15:0] holder [NFRAMES];
  logic [31:0] in_total;
  logic [31:0] out_total;
  logic [8:0]  live_procs;
  logic [16:0] frame_bytes;

  step_t    pending[$];
  pfa_rsp_t expected_rsp[$];
  int       errors;
  int       gap_left;
  int       quiet;
  int       wd_count;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [24:0] byte_count(int frames);
    longint p;
    p = longint'(frames) * longint'(frame_bytes);
    return (p > longint'(BYTES_MAX)) ? BYTES_MAX : p[24:0];
  endfunction

  // predicted response of one accepted request, updates the image
  function automatic pfa_rsp_t allocator_response(pfa_req_t r);
    pfa_rsp_t   o;
    logic [7:0] f;
    int         moved;
    o = '0;
    moved = 0;
    if (r.func == FUNC_ALLOC) begin
      if (r.pages_needed == 0 || int'(r.pages_needed) > free_frames) begin
        o.status = STATUS_REFUSED;
      end else begin
        for (int i = 0; i < int'(r.pages_needed); i++) begin
          f = free_list[list_head];
          if (i == 0) o.first_frame = f;
          list_head++;
          held[f] = 1'b1;
          holder[f] = r.process_id;
        end
        free_frames -= r.pages_needed;
        moved = r.pages_needed;
        in_total += r.pages_needed;
        if (live_procs < LIVE_MAX) live_procs++;
      end
    end else begin
      for (int i = 0; i < NFRAMES; i++) begin
        if (held[i] && holder[i] == r.process_id && free_frames < NFRAMES) begin
          held[i] = 1'b0;
          holder[i] = '0;
          free_list[list_tail] = i[7:0];
          list_tail++;
          free_frames++;
          moved++;
        end
      end
      if (moved == 0) begin
        o.status = STATUS_NONE_OWNED;
      end else begin
        out_total += moved;
        if (live_procs > 0) live_procs--;
      end
    end
    o.frames_moved    = moved[8:0];
    o.used_bytes      = byte_count(NFRAMES - free_frames);
    o.free_bytes      = byte_count(free_frames);
    o.paged_in_total  = in_total;
    o.paged_out_total = out_total;
    o.process_count   = live_procs;
    return o;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic add_req(logic fn, logic [15:0] pid, logic [8:0] pages, int gap);
    step_t s;
    s.kind = OP_REQ;
    s.req.func = fn;
    s.req.process_id = pid;
    s.req.pages_needed = pages;
    s.cfg = '0;
    s.gap = gap;
    pending.insert(pending.size(), s);
  endtask

  task automatic add_ctl(op_kind_t k, logic [16:0] v);
    step_t s;
    s.kind = k;
    s.req = '0;
    s.cfg = v;
    s.gap = 0;
    pending.insert(pending.size(), s);
  endtask

  // random request, mostly from a small pid pool so frees find frames
  task automatic add_random();
    logic [15:0] pid;
    logic [8:0]  pages;
    int          r;
    r = $urandom_range(0, 99);
    pid = (r < 85) ? 16'($urandom_range(0, 7)) : 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 5) pages = 9'd0;
    else if (r < 80) pages = 9'($urandom_range(1, 16));
    else pages = 9'($urandom);
    if ($urandom_range(0, 99) < 62) add_req(FUNC_ALLOC, pid, pages, pick_gap());
    else add_req(FUNC_FREE, pid, 9'($urandom), pick_gap());
  endtask

  // request and config driver
  always @(posedge clk) begin
    step_t nx;
    logic  start_n;
    logic  cfg_n;
    logic  idle_ok;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      req <= '0;
      cfg_data <= '0;
      gap_left = 0;
    end else begin
      start_n = start;
      cfg_n = cfg_valid;
      if (start && !busy) begin
        expected_rsp.insert(expected_rsp.size(), allocator_response(req));
        start_n = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        frame_bytes = cfg_data;
        cfg_n = 1'b0;
      end
      idle_ok = (expected_rsp.size() == 0) && (quiet >= SETTLE);
      if (!start_n && !cfg_n && pending.size() != 0) begin
        nx = pending[0];
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          case (nx.kind)
            OP_REQ: begin
              req <= nx.req;
              start_n = 1'b1;
              gap_left = nx.gap;
              void'(pending.pop_front());
            end
            OP_CFG: if (idle_ok) begin
              cfg_data <= nx.cfg;
              cfg_n = 1'b1;
              void'(pending.pop_front());
            end
            default: if (idle_ok) begin
              void'(pending.pop_front());
            end
          endcase
        end
      end
      start <= start_n;
      cfg_valid <= cfg_n;
    end
  end

  // response monitor
  always @(posedge clk) begin
    pfa_rsp_t w;
    if (rst) begin
      quiet <= 0;
    end else begin
      if (done || expected_rsp.size() != 0) quiet <= 0;
      else quiet <= quiet + 1;
      if (done) begin
        if (expected_rsp.size() == 0) begin
          $display("response with no request outstanding at %0t", $realtime);
          errors++;
        end else begin
          w = expected_rsp.pop_front();
          if (rsp.status !== w.status) report("status", rsp.status, w.status);
          if (rsp.first_frame !== w.first_frame)
            report("first_frame", rsp.first_frame, w.first_frame);
          if (rsp.frames_moved !== w.frames_moved)
            report("frames_moved", rsp.frames_moved, w.frames_moved);
          if (rsp.used_bytes !== w.used_bytes)
            report("used_bytes", rsp.used_bytes, w.used_bytes);
          if (rsp.free_bytes !== w.free_bytes)
            report("free_bytes", rsp.free_bytes, w.free_bytes);
          if (rsp.paged_in_total !== w.paged_in_total)
            report("paged_in_total", rsp.paged_in_total, w.paged_in_total);
          if (rsp.paged_out_total !== w.paged_out_total)
            report("paged_out_total", rsp.paged_out_total, w.paged_out_total);
          if (rsp.process_count !== w.process_count)
            report("process_count", rsp.process_count, w.process_count);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      wd_count <= 0;
    end else if (wd_count >= WD_LIMIT) begin
      $display("[paging_frame_allocator_top] ERROR");
      $finish;
    end else begin
      wd_count <= wd_count + 1;
    end
  end

  initial begin
    logic [16:0] v;
    errors = 0;
    wd_count = 0;
    quiet = 0;
    gap_left = 0;
    start = 1'b0;
    cfg_valid = 1'b0;
    req = '0;
    cfg_data = '0;
    for (int i = 0; i < NFRAMES; i++) begin
      free_list[i] = i[7:0];
      held[i] = OWNER_NONE;
      holder[i] = '0;
    end
    list_head = '0;
    list_tail = '0;
    free_frames = NFRAMES;
    in_total = '0;
    out_total = '0;
    live_procs = '0;
    frame_bytes = BPF_RESET;

    // directed: refusals, full allocation, empty free, byte extremes
    add_req(FUNC_ALLOC, 16'h0000, 9'd0, 0);
    add_req(FUNC_FREE, 16'h0000, 9'd0, 0);
    add_req(FUNC_ALLOC, 16'hFFFF, 9'd256, 0);
    add_req(FUNC_ALLOC, 16'h0001, 9'd1, 0);
    add_req(FUNC_ALLOC, 16'h0001, 9'd511, 2);
    add_req(FUNC_FREE, 16'hFFFF, 9'h1FF, 0);
    add_req(FUNC_ALLOC, 16'h0003, 9'd5, 0);
    add_req(FUNC_ALLOC, 16'h8000, 9'd7, 0);
    add_req(FUNC_ALLOC, 16'h0003, 9'd2, 1);
    add_req(FUNC_FREE, 16'h8000, 9'd0, 0);
    add_req(FUNC_ALLOC, 16'h5555, 9'd255, 0);
    add_req(FUNC_ALLOC, 16'hAAAA, 9'd9, 0);
    add_req(FUNC_FREE, 16'h0003, 9'd0, 0);
    add_req(FUNC_FREE, 16'hAAAA, 9'd0, 0);
    add_req(FUNC_FREE, 16'h5555, 9'd0, 0);
    add_ctl(OP_CFG, 17'd1);
    add_req(FUNC_ALLOC, 16'h0007, 9'd256, 0);
    add_req(FUNC_FREE, 16'h0007, 9'd0, 0);
    add_ctl(OP_CFG, 17'h1FFFF);
    add_req(FUNC_ALLOC, 16'h0009, 9'd200, 0);
    add_req(FUNC_FREE, 16'h0009, 9'd0, 0);
    add_ctl(OP_CFG, 17'h10000);
    add_req(FUNC_ALLOC, 16'h0002, 9'd256, 0);
    add_req(FUNC_FREE, 16'h0002, 9'd0, 0);

    // live process count climbs to saturation: repeated single-frame allocs
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 200; i++)
        add_req(FUNC_ALLOC, 16'h0042, 9'd1, (k == 0) ? 0 : pick_gap());
      add_req(FUNC_FREE, 16'h0042, 9'd0, 0);
    end

    // random phases with a fresh frame size each
    for (int ph = 0; ph < 4; ph++) begin
      v = (ph == 0) ? BPF_RESET : 17'($urandom_range(1, 17'h1FFFF));
      add_ctl(OP_CFG, v);
      for (int i = 0; i < 100; i++) begin
        if (ph == 1 && i == 50) add_ctl(OP_DRAIN, '0);
        add_random();
      end
    end

    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || start || cfg_valid || expected_rsp.size() != 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("[paging_frame_allocator_top] OK");
    end else begin
      $display("[paging_frame_allocator_top] ERROR");
    end
    $finish;
  end

endmodule
